/* sv/fhp_pkg.sv */
// shared constants, the reply hand-over struct and the hex conversion helpers
// of the framed hex port command unit; no dependencies
`default_nettype none

package fhp_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 14;
  localparam int unsigned STORE_LAST      = 10;
  localparam int unsigned REPLY_LEN       = 12;
  localparam int unsigned IDX_W           = 4;
  localparam int unsigned PADDR_W         = 3;

  localparam logic [7:0] STX_CODE        = 8'h02;
  localparam logic [7:0] ETX_CODE        = 8'h03;
  localparam logic [7:0] CMD_ALL         = 8'h41;
  localparam logic [7:0] CMD_WRITE       = 8'h57;
  localparam logic [7:0] PORT_FIRST      = 8'h41;
  localparam logic [7:0] PORT_LAST       = 8'h44;
  localparam logic [7:0] DIGIT_BASE      = 8'h30;
  localparam logic [7:0] LETTER_OFS      = 8'h37;
  localparam logic [7:0] PORT_RESET      = 8'hFF;
  localparam logic [7:0] DEV_ADDR_RESET  = 8'h52;

  typedef logic [3:0][7:0] port_vec_t;

  typedef struct packed {
    logic      load;
    logic [7:0] addr;
    logic [7:0] cmd;
    port_vec_t ports;
  } reply_load_t;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = c - DIGIT_BASE;
    if (v > 8'd9) begin
      v = c - LETTER_OFS;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    return {nibble_of(hi), nibble_of(lo)};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] w;
    w = {4'd0, n};
    return (n < 4'd10) ? (w + DIGIT_BASE) : (w + LETTER_OFS);
  endfunction

endpackage

`default_nettype wire

/* sv/fhp_frame.sv */
// frame collector: start hunting, byte store, address check, command decode and port latches
// depends on fhp_pkg
`default_nettype none

module fhp_frame #(
  parameter int unsigned FRAME_BYTES = fhp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rx_valid,
  output logic                    rx_stall,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [7:0]         device_address,
  input  wire logic               reply_busy,
  output fhp_pkg::reply_load_t    load
);
  import fhp_pkg::*;

  localparam int unsigned WP_W = $clog2(FRAME_BYTES);

  logic            in_frame;
  logic [WP_W-1:0] write_position;
  logic [7:0]      frame_store [1:STORE_LAST];
  logic [7:0]      eff [1:STORE_LAST];
  port_vec_t       ports;
  port_vec_t       ports_next;
  logic            accept;
  logic            is_etx;
  logic            done;
  logic [7:0]      sel;
  logic [1:0]      sel_idx;

  assign is_etx   = (rx_byte == ETX_CODE);
  assign rx_stall = reply_busy & in_frame & is_etx;
  assign accept   = rx_valid & ~rx_stall;
  assign done     = accept & in_frame & is_etx & (eff[1] == device_address);

  // store contents as they stand once this beat is written
  always_comb begin
    for (int k = 1; k <= STORE_LAST; k++) begin
      eff[k] = (in_frame && write_position == WP_W'(k)) ? rx_byte : frame_store[k];
    end
  end

  assign sel     = eff[4];
  assign sel_idx = 2'(sel - PORT_FIRST);

  always_comb begin
    ports_next = ports;
    if (eff[2] == CMD_ALL) begin
      for (int p = 0; p < 4; p++) begin
        ports_next[p] = pair_value(eff[3 + 2 * p], eff[4 + 2 * p]);
      end
    end else if (eff[2] == CMD_WRITE) begin
      if (sel >= PORT_FIRST && sel <= PORT_LAST) begin
        ports_next[sel_idx] = pair_value(eff[5], eff[6]);
      end
    end
  end

  always_comb begin
    load.load  = done;
    load.addr  = eff[1];
    load.cmd   = eff[2];
    load.ports = ports_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      write_position <= '0;
      ports          <= {4{PORT_RESET}};
      for (int k = 1; k <= STORE_LAST; k++) begin
        frame_store[k] <= 8'd0;
      end
    end else if (accept) begin
      if (!in_frame) begin
        if (rx_byte == STX_CODE) begin
          in_frame       <= 1'b1;
          write_position <= WP_W'(1);
        end
      end else begin
        for (int k = 1; k <= STORE_LAST; k++) begin
          frame_store[k] <= eff[k];
        end
        if (is_etx || write_position == WP_W'(FRAME_BYTES - 1)) begin
          in_frame       <= 1'b0;
          write_position <= '0;
        end else begin
          write_position <= write_position + WP_W'(1);
        end
        if (done) begin
          ports <= ports_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/fhp_reply.sv */
// reply sequencer: snapshot of one reply and the output register that sends its 12 beats
// depends on fhp_pkg
`default_nettype none

module fhp_reply (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fhp_pkg::reply_load_t load,
  output logic                      busy,
  output logic                      tx_valid,
  input  wire logic                 tx_stall,
  output logic [7:0]                tx_byte,
  output logic                      tx_last,
  output fhp_pkg::port_vec_t        tx_ports
);
  import fhp_pkg::*;

  logic [IDX_W-1:0] idx;
  logic [7:0]       snap_addr;
  logic [7:0]       snap_cmd;
  port_vec_t        snap_ports;
  logic             advance;
  logic             at_last;
  logic [IDX_W-1:0] hex_pos;
  logic [7:0]       hex_src;
  logic [7:0]       beat_byte;

  assign advance = busy & (~tx_valid | ~tx_stall);
  assign at_last = (idx == IDX_W'(REPLY_LEN - 1));
  assign hex_pos = idx - IDX_W'(3);
  assign hex_src = snap_ports[hex_pos[2:1]];

  always_comb begin
    if (idx == IDX_W'(0)) begin
      beat_byte = STX_CODE;
    end else if (idx == IDX_W'(1)) begin
      beat_byte = snap_addr;
    end else if (idx == IDX_W'(2)) begin
      beat_byte = snap_cmd;
    end else if (at_last) begin
      beat_byte = ETX_CODE;
    end else begin
      beat_byte = hex_char(hex_pos[0] ? hex_src[3:0] : hex_src[7:4]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      tx_valid <= 1'b0;
    end else begin
      if (load.load) begin
        busy       <= 1'b1;
        idx        <= '0;
        snap_addr  <= load.addr;
        snap_cmd   <= load.cmd;
        snap_ports <= load.ports;
      end else if (advance) begin
        idx <= idx + IDX_W'(1);
        if (at_last) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        tx_valid <= 1'b1;
        tx_byte  <= beat_byte;
        tx_last  <= at_last;
        tx_ports <= snap_ports;
      end else if (tx_valid && !tx_stall) begin
        tx_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/framed_hex_port_command_unit_core.sv */
// a matching ETX loads the reply snapshot; the first beat then enters the output register
// throughput: one received byte per cycle; a closing ETX stalls while a reply is still draining
// a reply is 12 beats, one per cycle while the output side does not stall
// reset (synchronous, rst high): STX hunt, store cleared, port latches 0xFF, address 0x52
// top level: configuration register port, frame collector and reply sequencer
// depends on fhp_pkg, fhp_frame, fhp_reply
`default_nettype none

module framed_hex_port_command_unit_core #(
  parameter int unsigned FRAME_BYTES = fhp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rx_valid,
  output logic                             rx_stall,
  input  wire logic [7:0]                  rx_byte,
  output logic                             tx_valid,
  input  wire logic                        tx_stall,
  output logic [7:0]                       tx_byte,
  output logic                             tx_last,
  output logic [7:0]                       port_a_value,
  output logic [7:0]                       port_b_value,
  output logic [7:0]                       port_c_value,
  output logic [7:0]                       port_d_value,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fhp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import fhp_pkg::*;

  logic [7:0]  device_address;
  logic        reply_busy;
  reply_load_t load;
  port_vec_t   tx_ports;
  logic        addr_hit;

  assign pready   = 1'b1;
  assign addr_hit = (paddr[PADDR_W-1] == 1'b0);
  assign prdata   = addr_hit ? {24'd0, device_address} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
    end else if (psel && penable && pwrite && pready && addr_hit) begin
      device_address <= pwdata[7:0];
    end
  end

  fhp_frame #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .device_address(device_address),
    .reply_busy    (reply_busy),
    .load          (load)
  );

  fhp_reply u_reply (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .busy    (reply_busy),
    .tx_valid(tx_valid),
    .tx_stall(tx_stall),
    .tx_byte (tx_byte),
    .tx_last (tx_last),
    .tx_ports(tx_ports)
  );

  assign port_a_value = tx_ports[0];
  assign port_b_value = tx_ports[1];
  assign port_c_value = tx_ports[2];
  assign port_d_value = tx_ports[3];

`ifndef SYNTHESIS
  a_last_is_etx: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_last |-> tx_byte == ETX_CODE)
    else $error("last reply beat is not ETX");

  a_reply_starts_stx: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(tx_valid && !tx_stall && tx_last) && tx_valid
      |-> tx_byte == STX_CODE && !tx_last)
    else $error("reply does not open with STX");

  a_ports_steady: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_stall && !tx_last |=> tx_valid && $stable(tx_ports))
    else $error("reply broken or port values changed within a reply");
`endif

endmodule

`default_nettype wire
